// File: design/mah_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mah_pkg
// Shared types and constants of the attitude filter and its serial unit.
// ----------------------------------------------------------------------------
package mah_pkg;

    localparam int QUAT_FRAC_BITS = 30;
    localparam int ALU_W          = 64;
    localparam int S_TDATA_W      = 120;
    localparam int M_TDATA_W      = 208;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 48;

    localparam logic signed [16:0] GOFF_X_RST   = -17'sd999;
    localparam logic signed [16:0] GOFF_Y_RST   = -17'sd35;
    localparam logic signed [16:0] GOFF_Z_RST   = -17'sd164;
    localparam logic [47:0]        AOFF_RST     = 48'hFD44_FFB0_0109;
    localparam logic [47:0]        ASCL_RST     = 48'h40E5_4000_3F9E;
    localparam logic [23:0]        KP_RST       = 24'd1966080;
    localparam logic [23:0]        KI_RST       = 24'd0;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic                    start;
        alu_op_t                 op;
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
    } alu_cmd_t;

    typedef struct packed {
        logic                    done;
        logic signed [ALU_W-1:0] res;
    } alu_rsp_t;

    typedef enum logic [2:0] {
        REG_GYRO_OFF_X  = 3'd0,
        REG_GYRO_OFF_Y  = 3'd1,
        REG_GYRO_OFF_Z  = 3'd2,
        REG_ACCEL_OFFS  = 3'd3,
        REG_ACCEL_SCLS  = 3'd4,
        REG_PROP_GAIN   = 3'd5,
        REG_INTEG_GAIN  = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    typedef enum logic [4:0] {
        SP_ACAL,
        SP_RATE,
        SP_SSQ,
        SP_NRM,
        SP_UNIT,
        SP_V,
        SP_E,
        SP_KIE,
        SP_KIUS,
        SP_KIDIV,
        SP_KPE,
        SP_HMUL,
        SP_HDIV,
        SP_NQ,
        SP_QS,
        SP_QN,
        SP_QDIV
    } step_t;

    typedef struct packed {
        logic       neg;
        logic [1:0] ia;
        logic [1:0] ib;
    } prod_tap_t;

endpackage
`default_nettype wire

// File: design/mah_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mah_alu
// Bit-serial multiply, restoring divide and integer square root on 64 bits.
// ----------------------------------------------------------------------------
module mah_alu (
    input  logic               aclk,
    input  logic               aresetn,
    input  mah_pkg::alu_cmd_t  cmd,
    output mah_pkg::alu_rsp_t  rsp
);
    import mah_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    alu_op_t                 op_reg;
    logic                    neg_reg;
    logic [ALU_W-1:0]        x_reg;
    logic [ALU_W-1:0]        y_reg;
    logic [ALU_W:0]          z_reg;
    logic [6:0]              cnt_reg;
    logic signed [ALU_W-1:0] res_reg;

    logic [ALU_W-1:0] a_mag;
    logic [ALU_W-1:0] b_mag;
    logic [ALU_W-1:0] mul_sum;
    logic [ALU_W:0]   rem_sh;
    logic             rem_ge;
    logic [ALU_W:0]   rem_sub;
    logic [ALU_W-1:0] sq_trial;
    logic             sq_ge;
    logic             fin;

    assign a_mag    = cmd.a[ALU_W-1] ? ALU_W'(-cmd.a) : ALU_W'(cmd.a);
    assign b_mag    = cmd.b[ALU_W-1] ? ALU_W'(-cmd.b) : ALU_W'(cmd.b);
    assign mul_sum  = z_reg[ALU_W-1:0] + x_reg;
    assign rem_sh   = {z_reg[ALU_W-1:0], x_reg[ALU_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, y_reg};
    assign rem_sub  = rem_sh - {1'b0, y_reg};
    assign sq_trial = z_reg[ALU_W-1:0] + y_reg;
    assign sq_ge    = x_reg >= sq_trial;

    always_comb begin
        unique case (op_reg)
            ALU_MUL:  fin = busy_reg && (y_reg == '0);
            ALU_DIV:  fin = busy_reg && (cnt_reg == '0);
            ALU_SQRT: fin = busy_reg && (y_reg == '0);
            default:  fin = busy_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= fin;
            if (cmd.start) begin
                busy_reg <= 1'b1;
            end else if (fin) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg <= cmd.op;
            z_reg  <= '0;
            unique case (cmd.op)
                ALU_MUL, ALU_DIV: begin
                    x_reg   <= a_mag;
                    y_reg   <= b_mag;
                    neg_reg <= cmd.a[ALU_W-1] ^ cmd.b[ALU_W-1];
                    cnt_reg <= 7'(ALU_W);
                end
                default: begin
                    x_reg   <= ALU_W'(cmd.a);
                    y_reg   <= ALU_W'(1) << (ALU_W - 2);
                    neg_reg <= 1'b0;
                    cnt_reg <= '0;
                end
            endcase
        end else if (fin) begin
            unique case (op_reg)
                ALU_MUL:  res_reg <= neg_reg ? -$signed(z_reg[ALU_W-1:0])
                                             : $signed(z_reg[ALU_W-1:0]);
                ALU_DIV:  res_reg <= neg_reg ? -$signed(x_reg) : $signed(x_reg);
                default:  res_reg <= $signed(z_reg[ALU_W-1:0]);
            endcase
        end else if (busy_reg) begin
            unique case (op_reg)
                ALU_MUL: begin
                    if (y_reg[0]) begin
                        z_reg <= {1'b0, mul_sum};
                    end
                    x_reg <= x_reg << 1;
                    y_reg <= y_reg >> 1;
                end
                ALU_DIV: begin
                    cnt_reg <= cnt_reg - 7'd1;
                    x_reg   <= {x_reg[ALU_W-2:0], rem_ge};
                    z_reg   <= rem_ge ? rem_sub : rem_sh;
                end
                default: begin
                    if (sq_ge) begin
                        x_reg <= x_reg - sq_trial;
                        z_reg <= {1'b0, (z_reg[ALU_W-1:0] >> 1) + y_reg};
                    end else begin
                        z_reg <= {1'b0, z_reg[ALU_W-1:0] >> 1};
                    end
                    y_reg <= y_reg >> 2;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("serial unit done held longer than one cycle");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> busy_reg)
        else $error("serial unit not busy after start");

    a_root_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && op_reg == ALU_SQRT) |-> $onehot0(y_reg))
        else $error("square root trial bit not single");

endmodule
`default_nettype wire

// File: design/mahony_imu_attitude_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mahony_imu_attitude_filter
// Calibrates one six-axis IMU sample and runs one Mahony attitude step.
// ----------------------------------------------------------------------------
// One item in gives one item out: the updated Q2.30 quaternion, the Q18.8
// calibrated accelerometer and a flag set when the accelerometer norm is zero
// and the attitude is held. Every multiply, divide and square root goes
// through one bit-serial unit, one operation at a time, each started from
// an issue state. A new item is taken once the previous update is finished,
// while its result waits in the output register. Configuration writes land
// at once on cfg_we.
// ----------------------------------------------------------------------------
module mahony_imu_attitude_filter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw,
    // gyro_z_raw, elapsed_us
    input  logic [mah_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // quat_w, quat_x, quat_y, quat_z, accel_cal_x, accel_cal_y, accel_cal_z
    output logic [mah_pkg::M_TDATA_W-1:0]   m_tdata,
    // update_skipped
    output logic                            m_tuser,
    input  logic                            cfg_we,
    input  logic [mah_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mah_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import mah_pkg::*;

    localparam int F       = QUAT_FRAC_BITS;
    localparam int V_SHIFT = 2 * F - 30;
    localparam logic signed [ALU_W-1:0] GYRO_SCALE = 64'sd73204415;
    localparam logic signed [ALU_W-1:0] USEC_DIV   = 64'sd1000000;
    localparam logic signed [ALU_W-1:0] HALF_DIV   = 64'sd2000000;
    localparam logic signed [ALU_W-1:0] V_BIAS     = 64'sd1 <<< (2 * F - 1);
    localparam logic signed [ALU_W-1:0] H_LIM      = 64'sd1 <<< 30;
    localparam logic signed [ALU_W-1:0] S32_HI     = 64'sd2147483647;
    localparam logic signed [ALU_W-1:0] S32_LO     = -64'sd2147483648;
    localparam logic signed [ALU_W-1:0] S26_HI     = 64'sd33554431;
    localparam logic signed [ALU_W-1:0] S26_LO     = -64'sd33554432;
    localparam logic signed [31:0]      QUAT_ONE   = 32'(64'sd1 <<< F);

    function automatic logic signed [ALU_W-1:0] rnd(input logic signed [ALU_W-1:0] x,
                                                    input int unsigned n);
        rnd = (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ALU_W-1:0] x);
        if (x > S32_HI) begin
            sat32 = 32'(S32_HI);
        end else if (x < S32_LO) begin
            sat32 = 32'(S32_LO);
        end else begin
            sat32 = 32'(x);
        end
    endfunction

    function automatic logic signed [25:0] sat26(input logic signed [ALU_W-1:0] x);
        if (x > S26_HI) begin
            sat26 = 26'(S26_HI);
        end else if (x < S26_LO) begin
            sat26 = 26'(S26_LO);
        end else begin
            sat26 = 26'(x);
        end
    endfunction

    function automatic logic signed [31:0] clamp_h(input logic signed [ALU_W-1:0] x);
        if (x > H_LIM) begin
            clamp_h = 32'(H_LIM);
        end else if (x < -H_LIM) begin
            clamp_h = 32'(-H_LIM);
        end else begin
            clamp_h = 32'(x);
        end
    endfunction

    // gravity half-vector products over the quaternion
    function automatic prod_tap_t v_tap(input logic [3:0] j);
        unique case (j)
            4'd0:    v_tap = '{neg: 1'b0, ia: 2'd1, ib: 2'd3};
            4'd1:    v_tap = '{neg: 1'b1, ia: 2'd0, ib: 2'd2};
            4'd2:    v_tap = '{neg: 1'b0, ia: 2'd0, ib: 2'd1};
            4'd3:    v_tap = '{neg: 1'b0, ia: 2'd2, ib: 2'd3};
            4'd4:    v_tap = '{neg: 1'b0, ia: 2'd0, ib: 2'd0};
            default: v_tap = '{neg: 1'b0, ia: 2'd3, ib: 2'd3};
        endcase
    endfunction

    // cross product of unit accel and half-vector
    function automatic prod_tap_t e_tap(input logic [3:0] j);
        unique case (j)
            4'd0:    e_tap = '{neg: 1'b0, ia: 2'd1, ib: 2'd2};
            4'd1:    e_tap = '{neg: 1'b1, ia: 2'd2, ib: 2'd1};
            4'd2:    e_tap = '{neg: 1'b0, ia: 2'd2, ib: 2'd0};
            4'd3:    e_tap = '{neg: 1'b1, ia: 2'd0, ib: 2'd2};
            4'd4:    e_tap = '{neg: 1'b0, ia: 2'd0, ib: 2'd1};
            default: e_tap = '{neg: 1'b1, ia: 2'd1, ib: 2'd0};
        endcase
    endfunction

    // quaternion rate products, three per component
    function automatic prod_tap_t nq_tap(input logic [3:0] j);
        unique case (j)
            4'd0:    nq_tap = '{neg: 1'b1, ia: 2'd1, ib: 2'd0};
            4'd1:    nq_tap = '{neg: 1'b1, ia: 2'd2, ib: 2'd1};
            4'd2:    nq_tap = '{neg: 1'b1, ia: 2'd3, ib: 2'd2};
            4'd3:    nq_tap = '{neg: 1'b0, ia: 2'd0, ib: 2'd0};
            4'd4:    nq_tap = '{neg: 1'b0, ia: 2'd2, ib: 2'd2};
            4'd5:    nq_tap = '{neg: 1'b1, ia: 2'd3, ib: 2'd1};
            4'd6:    nq_tap = '{neg: 1'b0, ia: 2'd0, ib: 2'd1};
            4'd7:    nq_tap = '{neg: 1'b1, ia: 2'd1, ib: 2'd2};
            4'd8:    nq_tap = '{neg: 1'b0, ia: 2'd3, ib: 2'd0};
            4'd9:    nq_tap = '{neg: 1'b0, ia: 2'd0, ib: 2'd2};
            4'd10:   nq_tap = '{neg: 1'b0, ia: 2'd1, ib: 2'd1};
            default: nq_tap = '{neg: 1'b1, ia: 2'd2, ib: 2'd0};
        endcase
    endfunction

    function automatic logic [1:0] nq_grp(input logic [3:0] j);
        priority if (j < 4'd3) begin
            nq_grp = 2'd0;
        end else if (j < 4'd6) begin
            nq_grp = 2'd1;
        end else if (j < 4'd9) begin
            nq_grp = 2'd2;
        end else begin
            nq_grp = 2'd3;
        end
    endfunction

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic [3:0] idx_reg, idx_next;
    logic       skip_reg, skip_next;

    logic signed [16:0] goff_reg [3];
    logic [47:0]        aoff_reg;
    logic [47:0]        ascl_reg;
    logic [23:0]        kp_reg;
    logic [23:0]        ki_reg;

    logic signed [15:0] araw_reg [3];
    logic signed [15:0] graw_reg [3];
    logic [19:0]        us_reg;

    logic signed [25:0]      acal_reg [3];
    logic signed [39:0]      rate_reg [3];
    logic signed [31:0]      unit_reg [3];
    logic signed [33:0]      v_reg    [3];
    logic signed [33:0]      e_reg    [3];
    logic signed [31:0]      h_reg    [3];
    logic signed [31:0]      nq_reg   [4];
    logic signed [31:0]      q_reg    [4];
    logic signed [31:0]      ifb_reg  [3];
    logic signed [ALU_W-1:0] acc_reg;
    logic signed [ALU_W-1:0] t_reg;
    logic [32:0]             nrm_reg;

    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   out_data_reg;
    logic                   out_skip_reg;

    alu_cmd_t alu_cmd;
    alu_rsp_t alu_rsp;

    logic                    accept;
    logic                    wb;
    logic                    out_free;
    logic                    out_load;
    logic [1:0]              i2;
    logic [1:0]              grp;
    prod_tap_t               tap;
    logic signed [15:0]      aoff_sel;
    logic [15:0]             ascl_sel;
    logic signed [16:0]      adiff;
    logic signed [17:0]      gdiff;
    logic signed [ALU_W-1:0] res;
    logic signed [25:0]      acal_wb;
    logic signed [ALU_W-1:0] sum_wb;
    logic signed [31:0]      ifb_new;
    logic                    acal_zero;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign wb       = (state_reg == ST_WAIT) && alu_rsp.done;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;
    assign i2       = idx_reg[1:0];
    assign grp      = nq_grp(idx_reg);
    assign res      = alu_rsp.res;

    assign aoff_sel  = aoff_reg[16 * i2 +: 16];
    assign ascl_sel  = ascl_reg[16 * i2 +: 16];
    assign adiff     = 17'(araw_reg[i2]) - 17'(aoff_sel);
    assign gdiff     = (18'(graw_reg[i2]) <<< 1) - 18'(goff_reg[i2]);
    assign acal_wb   = sat26(rnd(res, 6));
    assign ifb_new   = sat32(ALU_W'(ifb_reg[i2]) + res);
    assign sum_wb    = tap.neg ? acc_reg - res : acc_reg + res;
    assign acal_zero = (acal_reg[0] == '0) && (acal_reg[1] == '0) && (acal_wb == '0);

    always_comb begin
        unique case (step_reg)
            SP_V:    tap = v_tap(idx_reg);
            SP_E:    tap = e_tap(idx_reg);
            SP_NQ:   tap = nq_tap(idx_reg);
            default: tap = '{neg: 1'b0, ia: i2, ib: i2};
        endcase
    end

    always_comb begin
        alu_cmd.start = (state_reg == ST_ISSUE);
        alu_cmd.op    = ALU_MUL;
        alu_cmd.a     = '0;
        alu_cmd.b     = '0;
        unique case (step_reg)
            SP_ACAL: begin
                alu_cmd.a = ALU_W'(adiff);
                alu_cmd.b = ALU_W'({1'b0, ascl_sel});
            end
            SP_RATE: begin
                alu_cmd.a = ALU_W'(gdiff);
                alu_cmd.b = GYRO_SCALE;
            end
            SP_SSQ: begin
                alu_cmd.a = ALU_W'(acal_reg[i2]);
                alu_cmd.b = ALU_W'(acal_reg[i2]);
            end
            SP_NRM: begin
                alu_cmd.op = ALU_SQRT;
                alu_cmd.a  = acc_reg <<< 12;
            end
            SP_UNIT: begin
                alu_cmd.op = ALU_DIV;
                alu_cmd.a  = ALU_W'(acal_reg[i2]) <<< 36;
                alu_cmd.b  = ALU_W'({1'b0, nrm_reg});
            end
            SP_V: begin
                alu_cmd.a = ALU_W'(q_reg[tap.ia]);
                alu_cmd.b = ALU_W'(q_reg[tap.ib]);
            end
            SP_E: begin
                alu_cmd.a = ALU_W'(unit_reg[tap.ia]);
                alu_cmd.b = ALU_W'(v_reg[tap.ib]);
            end
            SP_KIE: begin
                alu_cmd.a = ALU_W'({1'b0, ki_reg});
                alu_cmd.b = ALU_W'(e_reg[i2]);
            end
            SP_KIUS: begin
                alu_cmd.a = t_reg;
                alu_cmd.b = ALU_W'({1'b0, us_reg});
            end
            SP_KIDIV: begin
                alu_cmd.op = ALU_DIV;
                alu_cmd.a  = t_reg;
                alu_cmd.b  = USEC_DIV;
            end
            SP_KPE: begin
                alu_cmd.a = ALU_W'({1'b0, kp_reg});
                alu_cmd.b = ALU_W'(e_reg[i2]);
            end
            SP_HMUL: begin
                alu_cmd.a = ALU_W'(rate_reg[i2]);
                alu_cmd.b = ALU_W'({1'b0, us_reg});
            end
            SP_HDIV: begin
                alu_cmd.op = ALU_DIV;
                alu_cmd.a  = t_reg <<< 6;
                alu_cmd.b  = HALF_DIV;
            end
            SP_NQ: begin
                alu_cmd.a = ALU_W'(q_reg[tap.ia]);
                alu_cmd.b = ALU_W'(h_reg[tap.ib]);
            end
            SP_QS: begin
                alu_cmd.a = ALU_W'(nq_reg[i2]);
                alu_cmd.b = ALU_W'(nq_reg[i2]);
            end
            SP_QN: begin
                alu_cmd.op = ALU_SQRT;
                alu_cmd.a  = acc_reg;
            end
            SP_QDIV: begin
                alu_cmd.op = ALU_DIV;
                alu_cmd.a  = ALU_W'(nq_reg[i2]) <<< (F - 1);
                alu_cmd.b  = ALU_W'({1'b0, nrm_reg});
            end
            default: alu_cmd.op = ALU_MUL;
        endcase
    end

    mah_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (alu_cmd),
        .rsp     (alu_rsp)
    );

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        skip_next  = skip_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_ISSUE;
                    step_next  = SP_ACAL;
                    idx_next   = '0;
                    skip_next  = 1'b0;
                end
            end
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT: begin
                if (alu_rsp.done) begin
                    state_next = ST_ISSUE;
                    idx_next   = idx_reg + 4'd1;
                    unique case (step_reg)
                        SP_ACAL: begin
                            if (idx_reg == 4'd2) begin
                                idx_next = '0;
                                if (acal_zero) begin
                                    skip_next  = 1'b1;
                                    state_next = ST_OUT;
                                end else begin
                                    step_next = SP_RATE;
                                end
                            end
                        end
                        SP_RATE: begin
                            if (idx_reg == 4'd2) begin
                                idx_next  = '0;
                                step_next = SP_SSQ;
                            end
                        end
                        SP_SSQ: begin
                            if (idx_reg == 4'd2) begin
                                idx_next  = '0;
                                step_next = SP_NRM;
                            end
                        end
                        SP_NRM: begin
                            idx_next  = '0;
                            step_next = SP_UNIT;
                        end
                        SP_UNIT: begin
                            if (idx_reg == 4'd2) begin
                                idx_next  = '0;
                                step_next = SP_V;
                            end
                        end
                        SP_V: begin
                            if (idx_reg == 4'd5) begin
                                idx_next  = '0;
                                step_next = SP_E;
                            end
                        end
                        SP_E: begin
                            if (idx_reg == 4'd5) begin
                                idx_next  = '0;
                                step_next = (ki_reg != '0) ? SP_KIE : SP_KPE;
                            end
                        end
                        SP_KIE: begin
                            idx_next  = idx_reg;
                            step_next = SP_KIUS;
                        end
                        SP_KIUS: begin
                            idx_next  = idx_reg;
                            step_next = SP_KIDIV;
                        end
                        SP_KIDIV: begin
                            idx_next  = idx_reg;
                            step_next = SP_KPE;
                        end
                        SP_KPE: begin
                            idx_next  = idx_reg;
                            step_next = SP_HMUL;
                        end
                        SP_HMUL: begin
                            idx_next  = idx_reg;
                            step_next = SP_HDIV;
                        end
                        SP_HDIV: begin
                            if (idx_reg == 4'd2) begin
                                idx_next  = '0;
                                step_next = SP_NQ;
                            end else begin
                                step_next = (ki_reg != '0) ? SP_KIE : SP_KPE;
                            end
                        end
                        SP_NQ: begin
                            if (idx_reg == 4'd11) begin
                                idx_next  = '0;
                                step_next = SP_QS;
                            end
                        end
                        SP_QS: begin
                            if (idx_reg == 4'd3) begin
                                idx_next  = '0;
                                step_next = SP_QN;
                            end
                        end
                        SP_QN: begin
                            idx_next = '0;
                            if (res == '0) begin
                                state_next = ST_OUT;
                            end else begin
                                step_next = SP_QDIV;
                            end
                        end
                        SP_QDIV: begin
                            if (idx_reg == 4'd3) begin
                                idx_next   = '0;
                                state_next = ST_OUT;
                            end
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= SP_ACAL;
            idx_reg      <= '0;
            skip_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            skip_reg  <= skip_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goff_reg[0] <= GOFF_X_RST;
            goff_reg[1] <= GOFF_Y_RST;
            goff_reg[2] <= GOFF_Z_RST;
            aoff_reg    <= AOFF_RST;
            ascl_reg    <= ASCL_RST;
            kp_reg      <= KP_RST;
            ki_reg      <= KI_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_GYRO_OFF_X: goff_reg[0] <= cfg_wdata[16:0];
                REG_GYRO_OFF_Y: goff_reg[1] <= cfg_wdata[16:0];
                REG_GYRO_OFF_Z: goff_reg[2] <= cfg_wdata[16:0];
                REG_ACCEL_OFFS: aoff_reg    <= cfg_wdata;
                REG_ACCEL_SCLS: ascl_reg    <= cfg_wdata;
                REG_PROP_GAIN:  kp_reg      <= cfg_wdata[23:0];
                REG_INTEG_GAIN: ki_reg      <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // attitude and integral state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg[0]   <= QUAT_ONE;
            q_reg[1]   <= '0;
            q_reg[2]   <= '0;
            q_reg[3]   <= '0;
            ifb_reg[0] <= '0;
            ifb_reg[1] <= '0;
            ifb_reg[2] <= '0;
        end else if (wb) begin
            unique case (step_reg)
                SP_KIDIV: ifb_reg[i2] <= ifb_new;
                SP_QN: begin
                    if (res == '0) begin
                        q_reg[0] <= QUAT_ONE;
                        q_reg[1] <= '0;
                        q_reg[2] <= '0;
                        q_reg[3] <= '0;
                    end
                end
                SP_QDIV: q_reg[i2] <= sat32(res);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            araw_reg[0] <= s_tdata[15:0];
            araw_reg[1] <= s_tdata[31:16];
            araw_reg[2] <= s_tdata[47:32];
            graw_reg[0] <= s_tdata[63:48];
            graw_reg[1] <= s_tdata[79:64];
            graw_reg[2] <= s_tdata[95:80];
            us_reg      <= s_tdata[115:96];
            acc_reg     <= '0;
        end else if (wb) begin
            unique case (step_reg)
                SP_ACAL: acal_reg[i2] <= acal_wb;
                SP_RATE: rate_reg[i2] <= 40'(rnd(res, 16));
                SP_SSQ:  acc_reg      <= acc_reg + res;
                SP_NRM: begin
                    nrm_reg <= res[32:0];
                    acc_reg <= '0;
                end
                SP_UNIT: unit_reg[i2] <= 32'(res);
                SP_V: begin
                    if (idx_reg[0]) begin
                        v_reg[idx_reg[2:1]] <= 34'(rnd(sum_wb -
                            ((idx_reg[2:1] == 2'd2) ? V_BIAS : '0), V_SHIFT));
                        acc_reg <= '0;
                    end else begin
                        acc_reg <= sum_wb;
                    end
                end
                SP_E: begin
                    if (idx_reg[0]) begin
                        e_reg[idx_reg[2:1]] <= 34'(rnd(sum_wb, 30));
                        acc_reg <= '0;
                    end else begin
                        acc_reg <= sum_wb;
                    end
                end
                SP_KIE:   t_reg <= rnd(res, 22);
                SP_KIUS:  t_reg <= res;
                SP_KIDIV: rate_reg[i2] <= rate_reg[i2] + 40'(ifb_new);
                SP_KPE:   rate_reg[i2] <= rate_reg[i2] + 40'(rnd(res, 22));
                SP_HMUL:  t_reg <= res;
                SP_HDIV:  h_reg[i2] <= clamp_h(res);
                SP_NQ: begin
                    if (idx_reg == 4'd2 || idx_reg == 4'd5 || idx_reg == 4'd8 ||
                        idx_reg == 4'd11) begin
                        nq_reg[grp] <= sat32(ALU_W'(q_reg[grp]) + rnd(sum_wb, 30));
                        acc_reg     <= '0;
                    end else begin
                        acc_reg <= sum_wb;
                    end
                end
                SP_QS:   acc_reg <= acc_reg + $signed({2'b00, res[ALU_W-1:2]});
                SP_QN:   nrm_reg <= res[32:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {2'b00, acal_reg[2], acal_reg[1], acal_reg[0],
                             q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
            out_skip_reg <= skip_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_skip_reg;

endmodule
`default_nettype wire

// File: tb/tb_mahony_imu_attitude_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mahony_imu_attitude_filter
// Self-checking bench for the fixed-point Mahony attitude filter.
// ----------------------------------------------------------------------------
// IMU items are queued by the stimulus process and offered by a clocked
// driver with random gaps; a clocked monitor predicts the quaternion, the
// calibrated accelerometer and the skip flag for every accepted item and
// checks each result, field by field, against the oldest prediction. The run
// steps through several register settings, extremes included, with random
// back-pressure and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_mahony_imu_attitude_filter;
    import mah_pkg::*;

    localparam longint GYRO_RAD_Q40 = 73204415;
    localparam int     V_SHIFT      = 2 * QUAT_FRAC_BITS - 30;
    localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic [19:0]        us;
        logic signed [15:0] gz, gy, gx, az, ay, ax;
    } imu_item_t;

    typedef struct packed {
        logic               skipped;
        logic signed [25:0] acz, acy, acx;
        logic signed [31:0] qz, qy, qx, qw;
    } att_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // register copies
    logic signed [16:0] gyro_off [3];
    logic [47:0] acc_offs, acc_scls;
    logic [23:0] kp_gain, ki_gain;
    // filter state copies
    longint att_q [4];
    longint integ [3];

    imu_item_t   pend_q [$];
    att_result_t att_exp_q [$];
    int  src_idle = 7, snk_idle = 67, hold_cycles = 0, mismatches = 0;
    bit  s_took = 1'b0;

    mahony_imu_attitude_filter u_top (.*);

    always #5 aclk = ~aclk;

    function automatic longint rnd(longint x, int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint sat(longint x, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
    endfunction

    function automatic longint unsigned isqrt_u64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic att_result_t predict_attitude(imu_item_t it);
        longint acal[3], rate[3], unit[3], v[3], e[3], h[3], nq[4];
        longint araw[3], graw[3], off, scl, d, nrm, kp, ki, us, lim;
        longint unsigned s, qs;
        att_result_t r;
        araw = '{longint'(it.ax), longint'(it.ay), longint'(it.az)};
        graw = '{longint'(it.gx), longint'(it.gy), longint'(it.gz)};
        us = longint'(it.us);
        kp = longint'(kp_gain);
        ki = longint'(ki_gain);
        lim = longint'(1) <<< 30;
        s = 0;
        qs = 0;
        for (int i = 0; i < 3; i++) begin
            off = longint'($signed(acc_offs[16*i +: 16]));
            scl = longint'(acc_scls[16*i +: 16]);
            acal[i] = sat(rnd((araw[i] - off) * scl, 6), 26);
            rate[i] = rnd((2 * graw[i] - longint'(gyro_off[i])) * GYRO_RAD_Q40, 16);
        end
        r.skipped = (acal[0] == 0 && acal[1] == 0 && acal[2] == 0);
        if (!r.skipped) begin
            for (int i = 0; i < 3; i++) s += longint'(acal[i] * acal[i]);
            nrm = longint'(isqrt_u64(s << 12));
            for (int i = 0; i < 3; i++) unit[i] = (acal[i] * (longint'(1) <<< 36)) / nrm;
            v[0] = rnd(att_q[1] * att_q[3] - att_q[0] * att_q[2], V_SHIFT);
            v[1] = rnd(att_q[0] * att_q[1] + att_q[2] * att_q[3], V_SHIFT);
            v[2] = rnd(att_q[0] * att_q[0] + att_q[3] * att_q[3] -
                       (longint'(1) <<< (2 * QUAT_FRAC_BITS - 1)), V_SHIFT);
            e[0] = rnd(unit[1] * v[2] - unit[2] * v[1], 30);
            e[1] = rnd(unit[2] * v[0] - unit[0] * v[2], 30);
            e[2] = rnd(unit[0] * v[1] - unit[1] * v[0], 30);
            for (int i = 0; i < 3; i++) begin
                if (ki > 0) begin
                    d = rnd(ki * e[i], 22) * us / 1000000;
                    integ[i] = sat(integ[i] + d, 32);
                    rate[i] += integ[i];
                end
                rate[i] += rnd(kp * e[i], 22);
                h[i] = rate[i] * us * 64 / 2000000;
                h[i] = h[i] > lim ? lim : (h[i] < -lim ? -lim : h[i]);
            end
            nq[0] = att_q[0] + rnd(-att_q[1]*h[0] - att_q[2]*h[1] - att_q[3]*h[2], 30);
            nq[1] = att_q[1] + rnd(att_q[0]*h[0] + att_q[2]*h[2] - att_q[3]*h[1], 30);
            nq[2] = att_q[2] + rnd(att_q[0]*h[1] - att_q[1]*h[2] + att_q[3]*h[0], 30);
            nq[3] = att_q[3] + rnd(att_q[0]*h[2] + att_q[1]*h[1] - att_q[2]*h[0], 30);
            for (int i = 0; i < 4; i++) begin
                nq[i] = sat(nq[i], 32);
                qs += longint'(nq[i] * nq[i]) >> 2;
            end
            nrm = longint'(isqrt_u64(qs));
            if (nrm == 0) begin
                att_q = '{longint'(1) <<< QUAT_FRAC_BITS, 0, 0, 0};
            end else begin
                for (int i = 0; i < 4; i++)
                    att_q[i] = sat(nq[i] * (longint'(1) <<< (QUAT_FRAC_BITS - 1)) / nrm, 32);
            end
        end
        r.qw = 32'(att_q[0]);
        r.qx = 32'(att_q[1]);
        r.qy = 32'(att_q[2]);
        r.qz = 32'(att_q[3]);
        r.acx = 26'(acal[0]);
        r.acy = 26'(acal[1]);
        r.acz = 26'(acal[2]);
        return r;
    endfunction

    // driver: change inputs on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (pend_q.size() > 0 && $urandom_range(0, 99) >= src_idle) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, pend_q.pop_front()};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    // monitor: sample on the rising edge
    always @(posedge aclk) begin
        att_result_t got, want;
        s_took = s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[205:0]};
            if (att_exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = att_exp_q.pop_front();
                if (got.qw !== want.qw || got.qx !== want.qx || got.qy !== want.qy ||
                    got.qz !== want.qz || got.acx !== want.acx || got.acy !== want.acy ||
                    got.acz !== want.acz || got.skipped !== want.skipped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch q exp %h %h %h %h got %h %h %h %h",
                                 want.qw, want.qx, want.qy, want.qz,
                                 got.qw, got.qx, got.qy, got.qz,
                                 "  acal exp %h %h %h got %h %h %h  skip exp %b got %b",
                                 want.acx, want.acy, want.acz, got.acx, got.acy, got.acz,
                                 want.skipped, got.skipped);
                end
            end
        end
        if (aresetn && s_took)
            att_exp_q.push_back(predict_attitude(imu_item_t'(s_tdata[115:0])));
    end

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [47:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        case (addr)
            REG_GYRO_OFF_X: gyro_off[0] = val[16:0];
            REG_GYRO_OFF_Y: gyro_off[1] = val[16:0];
            REG_GYRO_OFF_Z: gyro_off[2] = val[16:0];
            REG_ACCEL_OFFS: acc_offs = val;
            REG_ACCEL_SCLS: acc_scls = val;
            REG_PROP_GAIN:  kp_gain = val[23:0];
            REG_INTEG_GAIN: ki_gain = val[23:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pend_q.size() > 0 || s_tvalid || att_exp_q.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic imu_item_t mk(int ax, int ay, int az, int gx, int gy, int gz, int us);
        imu_item_t it;
        it = '{us: 20'(us), gz: 16'(gz), gy: 16'(gy), gx: 16'(gx),
               az: 16'(az), ay: 16'(ay), ax: 16'(ax)};
        return it;
    endfunction

    function automatic imu_item_t rand_item(bit wild);
        imu_item_t it;
        int sel;
        it = imu_item_t'(116'({$urandom, $urandom, $urandom, $urandom}));
        sel = $urandom_range(0, 99);
        if (wild || sel < 8) return it;
        if (sel < 12) begin
            it.ax = acc_offs[15:0];
            it.ay = acc_offs[31:16];
            it.az = acc_offs[47:32];
        end else begin
            it.ax = 16'($urandom_range(0, 40000) - 20000);
            it.ay = 16'($urandom_range(0, 40000) - 20000);
            it.az = 16'($urandom_range(0, 40000) - 20000);
        end
        it.gx = 16'($urandom_range(0, 8000) - 4000);
        it.gy = 16'($urandom_range(0, 8000) - 4000);
        it.gz = 16'($urandom_range(0, 8000) - 4000);
        it.us = (sel < 20) ? 20'($urandom_range(0, 1048575)) : 20'($urandom_range(100, 20000));
        return it;
    endfunction

    task automatic run_random(int n, int wild_pct);
        repeat (n) pend_q.push_back(rand_item($urandom_range(0, 99) < wild_pct));
    endtask

    initial begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        gyro_off = '{GOFF_X_RST, GOFF_Y_RST, GOFF_Z_RST};
        acc_offs = AOFF_RST;
        acc_scls = ASCL_RST;
        kp_gain  = KP_RST;
        ki_gain  = KI_RST;
        att_q    = '{longint'(1) <<< QUAT_FRAC_BITS, 0, 0, 0};
        integ    = '{0, 0, 0};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        pend_q.push_back(mk(265, -80, 16384, 0, 0, 0, 1000));
        pend_q.push_back(mk(265, -80, -700, 32767, 32767, 32767, 1000));
        pend_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 1048575));
        pend_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, 0));
        pend_q.push_back(mk(16384, 0, 0, 32767, -32768, 32767, 1048575));
        pend_q.push_back(mk(0, 16384, 0, -999, -35, -164, 1000));
        pend_q.push_back(mk(-32768, 32767, 0, 0, 0, 0, 500000));
        pend_q.push_back(mk(265, -80, -701, 100, -100, 50, 1));
        pend_q.push_back(mk(0, 0, -16384, -32768, 0, 32767, 20000));
        pend_q.push_back(mk(265, -80, -700, 0, 0, 0, 0));
        pend_q.push_back(mk(1000, -2000, 15000, 200, 300, -400, 5000));
        pend_q.push_back(mk(32767, -32768, 32767, 0, 0, 0, 1048575));
        wait_drained();
        run_random(150, 5);
        wait_drained();

        cfg_write(REG_GYRO_OFF_X, 48'($urandom_range(0, 4000) - 2000));
        cfg_write(REG_GYRO_OFF_Y, 48'($urandom_range(0, 4000) - 2000));
        cfg_write(REG_GYRO_OFF_Z, 48'($urandom_range(0, 4000) - 2000));
        cfg_write(REG_ACCEL_OFFS, 48'({$urandom, $urandom}));
        cfg_write(REG_ACCEL_SCLS, {16'd16000 + 16'($urandom_range(0, 800)),
                                   16'd16000 + 16'($urandom_range(0, 800)),
                                   16'd16000 + 16'($urandom_range(0, 800))});
        cfg_write(REG_PROP_GAIN, 48'($urandom_range(0, 4000000)));
        cfg_write(REG_INTEG_GAIN, 48'd65536);
        src_idle = 67;
        snk_idle = 7;
        run_random(150, 5);
        hold_cycles = 8000;
        wait_drained();

        src_idle = 0;
        snk_idle = 0;
        cfg_write(REG_GYRO_OFF_X, 48'h1_0000);
        cfg_write(REG_GYRO_OFF_Y, 48'h0_FFFF);
        cfg_write(REG_GYRO_OFF_Z, 48'h0);
        cfg_write(REG_ACCEL_OFFS, 48'h7FFF_8000_7FFF);
        cfg_write(REG_ACCEL_SCLS, 48'hFFFF_FFFF_FFFF);
        cfg_write(REG_PROP_GAIN, 48'hFF_FFFF);
        cfg_write(REG_INTEG_GAIN, 48'hFF_FFFF);
        run_random(100, 50);
        wait_drained();

        cfg_write(REG_ACCEL_SCLS, 48'h0);
        cfg_write(REG_NONE, 48'({$urandom, $urandom}));
        run_random(20, 50);
        wait_drained();

        cfg_write(REG_ACCEL_OFFS, 48'h0);
        cfg_write(REG_ACCEL_SCLS, 48'h4000_4000_4000);
        cfg_write(REG_PROP_GAIN, 48'($urandom_range(0, 300000)));
        cfg_write(REG_INTEG_GAIN, 48'h0);
        run_random(170, 5);
        wait_drained();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
